// File: hw/rtl/length_prefixed_deframer_unit_defines.svh
// Assertion macros used by the deframer port checker.
`ifndef LENGTH_PREFIXED_DEFRAMER_UNIT_DEFINES_SVH
`define LENGTH_PREFIXED_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lpd_pkg.sv
// Types and constants of the length-prefixed deframer.
package lpd_pkg;

  localparam int DATA_W   = 8;
  localparam int LEN_W    = 16;
  localparam int MAX_W    = 17;

  localparam logic [MAX_W-1:0] MAX_TOTAL_RESET = 17'd1200;
  localparam logic [MAX_W-1:0] HEADER_BYTES    = 17'd3;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_ABORT = 1'b1;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_PAYLOAD = 2'd0,
    ST_LEN_ERR = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_ABORT   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_LEN_HI  = 4'b0001,
    S_LEN_LO  = 4'b0010,
    S_PROTO   = 4'b0100,
    S_PAYLOAD = 4'b1000
  } front_state_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] out_byte;
    logic [DATA_W-1:0] protocol;
    logic [LEN_W-1:0]  frame_length;
    logic              first;
    logic              last;
  } lpd_result_t;

endpackage

// File: hw/rtl/lpd_front.sv
// Front end: header parsing, frame classification and result generation.
module lpd_front
  import lpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              cmd,
  input  logic [DATA_W-1:0] in_byte,
  input  logic              cfg_we,
  input  logic [MAX_W-1:0]  cfg_value,
  output logic              push,
  output lpd_result_t       push_item
);

  front_state_t     state, state_next;
  logic [LEN_W-1:0] length_reg, length_next;
  logic [DATA_W-1:0] protocol_reg, protocol_next;
  logic [LEN_W-1:0] payload_count, payload_count_next;
  logic [MAX_W-1:0] max_total;
  logic [MAX_W-1:0] total_len;
  logic [MAX_W-1:0] count_inc;
  logic             is_last;

  assign total_len = {1'b0, length_reg} + HEADER_BYTES;
  assign count_inc = {1'b0, payload_count} + 17'd1;
  assign is_last   = count_inc >= {1'b0, length_reg};

  always_comb begin
    state_next         = state;
    length_next        = length_reg;
    protocol_next      = protocol_reg;
    payload_count_next = payload_count;
    push               = 1'b0;
    push_item          = '0;
    if (accept) begin
      if (cmd == CMD_ABORT) begin
        if (state == S_PAYLOAD) begin
          push                   = 1'b1;
          push_item.status       = ST_ABORT;
          push_item.protocol     = protocol_reg;
          push_item.frame_length = length_reg;
        end else if (state != S_LEN_HI) begin
          // partial header: nothing valid to report
          push             = 1'b1;
          push_item.status = ST_ABORT;
        end
        state_next         = S_LEN_HI;
        payload_count_next = '0;
      end else begin
        unique case (state)
          S_LEN_HI: begin
            length_next = {in_byte, 8'h00};
            state_next  = S_LEN_LO;
          end
          S_LEN_LO: begin
            length_next = {length_reg[LEN_W-1:DATA_W], in_byte};
            state_next  = S_PROTO;
          end
          S_PROTO: begin
            protocol_next = in_byte;
            if (total_len > max_total) begin
              push                   = 1'b1;
              push_item.status       = ST_LEN_ERR;
              push_item.protocol     = in_byte;
              push_item.frame_length = length_reg;
              state_next             = S_LEN_HI;
            end else if (length_reg == '0) begin
              push               = 1'b1;
              push_item.status   = ST_EMPTY;
              push_item.protocol = in_byte;
              state_next         = S_LEN_HI;
            end else begin
              state_next = S_PAYLOAD;
            end
            payload_count_next = '0;
          end
          S_PAYLOAD: begin
            push                   = 1'b1;
            push_item.status       = ST_PAYLOAD;
            push_item.out_byte     = in_byte;
            push_item.protocol     = protocol_reg;
            push_item.frame_length = length_reg;
            push_item.first        = (payload_count == '0);
            push_item.last         = is_last;
            if (is_last) begin
              state_next         = S_LEN_HI;
              payload_count_next = '0;
            end else begin
              payload_count_next = count_inc[LEN_W-1:0];
            end
          end
          default: begin
            state_next         = S_LEN_HI;
            payload_count_next = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LEN_HI;
      length_reg    <= '0;
      protocol_reg  <= '0;
      payload_count <= '0;
      max_total     <= MAX_TOTAL_RESET;
    end else begin
      state         <= state_next;
      length_reg    <= length_next;
      protocol_reg  <= protocol_next;
      payload_count <= payload_count_next;
      if (cfg_we) begin
        max_total <= cfg_value;
      end
    end
  end

endmodule

// File: hw/rtl/lpd_queue.sv
// Short result queue between front and back.
module lpd_queue
  import lpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  lpd_result_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output lpd_result_t pop_item
);

  lpd_result_t      entries [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == QCW'(QDEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/lpd_back.sv
// Back end: output register and stream packing of results.
module lpd_back
  import lpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_not_empty,
  input  lpd_result_t q_item,
  output logic        q_pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  lpd_result_t out_reg;
  logic        out_valid;

  // load whenever the register is empty or being drained
  assign q_pop = q_not_empty && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_reg <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_reg.frame_length, out_reg.protocol, out_reg.out_byte};
  assign m_axis_tuser  = {out_reg.first, out_reg.status};
  assign m_axis_tlast  = out_reg.last;

endmodule

// File: hw/rtl/length_prefixed_deframer_unit.sv
// Length-prefixed frame deframer: one received byte per cycle in while the
// queue has room, one result per cycle out while m_axis_tready is high. Each
// frame opens with a 3-byte header (16-bit big-endian payload length, then a
// protocol byte); payload bytes leave tagged with protocol, length and
// first/last marks, while oversize frames, empty frames and aborted partial
// frames leave as single status results. The header state machine in the
// front end takes one byte every cycle while the queue has room; results pass
// through a 4-entry queue and then an output register, and input stalls only
// once the queue is full. max_total_length (reset 1200) is written through
// the cfg port, which is always ready.
module length_prefixed_deframer_unit
  import lpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MAX_W-1:0]  cfg_data,       // max_total_length
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] in_byte
  input  logic              s_axis_tuser,   // [0] command
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [7:0] out_byte, [15:8] protocol,
                                            // [31:16] frame_length
  output logic [2:0]        m_axis_tuser,   // [1:0] status, [2] first
  output logic              m_axis_tlast    // last
);

  logic        q_full;
  logic        q_not_empty;
  logic        q_pop;
  logic        push;
  lpd_result_t push_item;
  lpd_result_t q_item;
  logic        accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (s_axis_tuser),
    .in_byte   (s_axis_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .push      (push),
    .push_item (push_item)
  );

  lpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_item)
  );

  lpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: hw/rtl/lpd_checker.sv
// Port-level checks on the deframer output, bound to the top level.
`include "length_prefixed_deframer_unit_defines.svh"

module lpd_checker
  import lpd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  `LPD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output transaction changed while stalled")

  // status results carry no byte and no frame marks
  `LPD_ASSERT_IMP(a_status_clean, m_axis_tvalid && m_axis_tuser[1:0] != ST_PAYLOAD, m_axis_tdata[7:0] == 8'h00 && !m_axis_tuser[2] && !m_axis_tlast, "status result with payload fields set")

  // a payload byte always belongs to a nonempty frame
  `LPD_ASSERT_IMP(a_payload_len, m_axis_tvalid && m_axis_tuser[1:0] == ST_PAYLOAD, m_axis_tdata[31:16] != 16'h0000, "payload byte with zero frame length")

  // single-byte frames are first and last at once
  `LPD_ASSERT_IMP(a_single_byte, m_axis_tvalid && m_axis_tuser[1:0] == ST_PAYLOAD && m_axis_tuser[2] && m_axis_tdata[31:16] == 16'h0001, m_axis_tlast, "one-byte frame without last mark")

endmodule

bind length_prefixed_deframer_unit lpd_checker u_lpd_checker (.*);

// File: test/length_prefixed_deframer_checker.sv
// Scoreboard for the deframer: predicts results from accepted transactions and compares them.
`timescale 1ns / 1ps
module length_prefixed_deframer_checker
  import lpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [MAX_W-1:0] cfg_data,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] in_byte
  input  logic             s_axis_tuser,   // [0] command
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [31:0]      m_axis_tdata,   // [7:0] out_byte, [15:8] protocol,
                                           // [31:16] frame_length
  input  logic [2:0]       m_axis_tuser,   // [1:0] status, [2] first
  input  logic             m_axis_tlast,   // last
  output int unsigned      fail_count,
  output int unsigned      outstanding,
  output int unsigned      results_checked
);

  lpd_result_t      pending_results[$];
  logic [MAX_W-1:0] max_total;
  logic             in_payload;
  logic [1:0]       hdr_count;
  logic [LEN_W-1:0] hdr_length;
  logic [7:0]       hdr_proto;
  logic [LEN_W-1:0] bytes_passed;

  function automatic lpd_result_t make_result(status_t st, logic [7:0] data_byte,
                                              logic [7:0] proto, logic [LEN_W-1:0] len,
                                              logic is_first, logic is_last);
    lpd_result_t r;
    r.status       = st;
    r.out_byte     = data_byte;
    r.protocol     = proto;
    r.frame_length = len;
    r.first        = is_first;
    r.last         = is_last;
    return r;
  endfunction

  task automatic back_to_hunting();
    in_payload   = 1'b0;
    hdr_count    = 2'd0;
    bytes_passed = '0;
  endtask

  task automatic deframe_byte(input logic cmd, input logic [7:0] data_byte);
    logic [LEN_W:0] next_count;
    logic           is_last;
    next_count = {1'b0, bytes_passed} + 1'b1;
    is_last    = (next_count >= {1'b0, hdr_length});
    if (cmd == CMD_ABORT) begin
      if (in_payload) begin
        pending_results.push_back(make_result(ST_ABORT, 8'h00, hdr_proto, hdr_length,
                                              1'b0, 1'b0));
        back_to_hunting();
      end else if (hdr_count != 2'd0) begin
        // no complete header yet, so protocol and length read as zero
        pending_results.push_back(make_result(ST_ABORT, 8'h00, 8'h00, '0, 1'b0, 1'b0));
        back_to_hunting();
      end
    end else if (in_payload) begin
      pending_results.push_back(make_result(ST_PAYLOAD, data_byte, hdr_proto, hdr_length,
                                            bytes_passed == '0, is_last));
      if (is_last) begin
        back_to_hunting();
      end else begin
        bytes_passed = next_count[LEN_W-1:0];
      end
    end else if (hdr_count == 2'd0) begin
      hdr_length = {data_byte, 8'h00};
      hdr_count  = 2'd1;
    end else if (hdr_count == 2'd1) begin
      hdr_length[7:0] = data_byte;
      hdr_count       = 2'd2;
    end else begin
      hdr_proto = data_byte;
      if ({1'b0, hdr_length} + HEADER_BYTES > max_total) begin
        pending_results.push_back(make_result(ST_LEN_ERR, 8'h00, hdr_proto, hdr_length,
                                              1'b0, 1'b0));
        back_to_hunting();
      end else if (hdr_length == '0) begin
        pending_results.push_back(make_result(ST_EMPTY, 8'h00, hdr_proto, '0, 1'b0, 1'b0));
        back_to_hunting();
      end else begin
        hdr_count    = 2'd0;
        in_payload   = 1'b1;
        bytes_passed = '0;
      end
    end
  endtask

  task automatic report_field(input string field, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  task automatic check_result();
    lpd_result_t want;
    lpd_result_t got;
    got = make_result(status_t'(m_axis_tuser[1:0]), m_axis_tdata[7:0], m_axis_tdata[15:8],
                      m_axis_tdata[31:16], m_axis_tuser[2], m_axis_tlast);
    if (pending_results.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result: expected none, got status %0d byte %0d proto %0d len %0d first %0b last %0b",
               $time, got.status, got.out_byte, got.protocol, got.frame_length,
               got.first, got.last);
    end else begin
      want = pending_results.pop_front();
      results_checked++;
      report_field("status", want.status, got.status);
      report_field("out_byte", want.out_byte, got.out_byte);
      report_field("protocol", want.protocol, got.protocol);
      report_field("frame_length", want.frame_length, got.frame_length);
      report_field("first", want.first, got.first);
      report_field("last", want.last, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_results.delete();
      max_total       = MAX_TOTAL_RESET;
      hdr_length      = '0;
      hdr_proto       = 8'h00;
      back_to_hunting();
      fail_count      = 0;
      results_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_total = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tuser, s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// File: test/length_prefixed_deframer_unit_tb.sv
// Testbench top for the deframer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module length_prefixed_deframer_unit_tb;
  import lpd_pkg::*;

  localparam int CYCLE_LIMIT       = 200000;
  localparam int DRAIN_CYCLES      = 16;
  localparam int ITEMS_PER_SEGMENT = 57;

  logic             clk;
  logic             rst           = 1'b1;
  logic             cfg_valid     = 1'b0;
  logic             cfg_ready;
  logic [MAX_W-1:0] cfg_data      = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic             s_axis_tuser  = 1'b0;   // [0] command
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [31:0]      m_axis_tdata;           // [7:0] out_byte, [15:8] protocol,
                                            // [31:16] frame_length
  logic [2:0]       m_axis_tuser;           // [1:0] status, [2] first
  logic             m_axis_tlast;           // last

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned cfg_writes    = 0;
  int unsigned cycles        = 0;
  logic [MAX_W-1:0] max_now  = MAX_TOTAL_RESET;

  // visits every listed maximum across the segments; the final slot picks a small random one
  logic [MAX_W-1:0] seg_max[10] = '{17'd3, 17'd4, 17'd12, 17'd40, 17'd67, 17'd1200,
                                    17'd65538, 17'h1FFFF, 17'd0, 17'd0};

  length_prefixed_deframer_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  length_prefixed_deframer_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .results_checked(results_checked)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles, outstanding);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // One transaction on the input stream; valid drops only when the sender idles or settles.
  task automatic send_item(input logic cmd, input logic [7:0] data_byte, input bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = data_byte;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    if (counted) items_sent++;
  endtask

  task automatic send_header(input logic [LEN_W-1:0] len, input logic [7:0] proto);
    send_item(CMD_DATA, len[15:8], 1'b1);
    send_item(CMD_DATA, len[7:0], 1'b1);
    send_item(CMD_DATA, proto, 1'b1);
  endtask

  // Hold the input off until every expected result is out, then let the pipe settle.
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_max(input logic [MAX_W-1:0] value);
    settle();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    max_now   = value;
    cfg_writes++;
  endtask

  task automatic random_frame();
    int         mx;
    int         hi;
    int         lo;
    int         len;
    int         cut;
    int         pick;
    logic [7:0] proto;
    mx    = int'(max_now);
    hi    = (mx - 3 > 65535) ? 65535 : mx - 3;  // longest payload that still fits
    pick  = $urandom_range(99);
    proto = 8'($urandom);
    if (pick < 70 && mx >= 3) begin
      if (hi == 0 || $urandom_range(9) == 0) begin
        len = 0;
      end else if (hi <= 48 && $urandom_range(4) == 0) begin
        len = hi;
      end else begin
        len = $urandom_range((hi < 16) ? hi : 16, 1);
      end
      send_header(16'(len), proto);
      cut = len;
      if (len > 0 && $urandom_range(15) == 0) cut = $urandom_range(len - 1);
      for (int i = 0; i < cut; i++) send_item(CMD_DATA, 8'($urandom), 1'b1);
      if (cut < len) send_item(CMD_ABORT, 8'($urandom), 1'b1);
    end else if (pick < 82 && mx <= 65537) begin
      // oversize header, half of them just one past the limit
      lo  = (mx > 2) ? mx - 2 : 0;
      len = ($urandom_range(1) == 0) ? lo : $urandom_range(65535, lo);
      send_header(16'(len), proto);
    end else if (pick < 92) begin
      repeat ($urandom_range(2, 1)) send_item(CMD_DATA, 8'($urandom), 1'b1);
      send_item(CMD_ABORT, 8'($urandom), 1'b1);
    end else begin
      send_item(CMD_ABORT, 8'($urandom), 1'b0);
    end
  endtask

  initial begin
    int unsigned      target;
    bit               paused;
    logic [MAX_W-1:0] seg_value;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset maximum of 1200
    send_item(CMD_ABORT, 8'hFF, 1'b0);          // abort with nothing pending
    send_header(16'd2, 8'hA5);
    send_item(CMD_DATA, 8'hFF, 1'b1);
    send_item(CMD_DATA, 8'h00, 1'b1);
    send_header(16'd0, 8'hFF);                  // empty frame
    send_header(16'hFFFF, 8'h00);               // length error
    send_item(CMD_DATA, 8'h12, 1'b1);
    send_item(CMD_ABORT, 8'h00, 1'b1);          // abort inside a header
    send_header(16'd5, 8'h33);
    send_item(CMD_DATA, 8'hC3, 1'b1);
    send_item(CMD_ABORT, 8'h5A, 1'b1);          // abort inside a payload
    write_max(17'd0);
    send_header(16'd0, 8'h11);                  // even an empty frame is too long
    write_max(17'd65538);
    send_header(16'hFFFF, 8'h77);               // longest frame fits exactly
    send_item(CMD_DATA, 8'h5E, 1'b1);
    send_item(CMD_ABORT, 8'h00, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 79 : 0;
      recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 28 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        seg_value = seg_max[(ph * 6 + seg) % 10];
        if ((ph * 6 + seg) % 10 == 9) seg_value = MAX_W'($urandom_range(60, 3));
        write_max(seg_value);
        target = items_sent + ITEMS_PER_SEGMENT;
        paused = 1'b0;
        while (items_sent < target) begin
          random_frame();
          if (!paused && items_sent + ITEMS_PER_SEGMENT / 2 >= target) begin
            settle();
            paused = 1'b1;
          end
        end
      end
    end

    settle();
    $display("Sent %0d stream transactions over %0d max_total_length settings,", items_sent,
             cfg_writes);
    $display("covering payload, length error, empty and abort cases; %0d results checked.",
             results_checked);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: length_prefixed_deframer_unit.f
+incdir+hw/rtl
hw/rtl/lpd_pkg.sv
hw/rtl/lpd_front.sv
hw/rtl/lpd_queue.sv
hw/rtl/lpd_back.sv
hw/rtl/length_prefixed_deframer_unit.sv
hw/rtl/lpd_checker.sv
test/length_prefixed_deframer_checker.sv
test/length_prefixed_deframer_unit_tb.sv
